// ===== rtl/core/grid_convex_hull_macros.svh =====
// Assertion macros shared by the grid convex hull RTL.
`ifndef GRID_CONVEX_HULL_MACROS_SVH
`define GRID_CONVEX_HULL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GCH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid convex hull check failed");
`define GCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid convex hull check failed");
`else
`define GCH_ASSERT_IMPL(label, ante, cons)
`define GCH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/gch_pkg.sv =====
// Shared constants and types of the grid convex hull.
package gch_pkg;
  localparam int ROWS = 1024;
  localparam int COORD_BITS = 10;
  localparam int CHAIN_DEPTH = 32;
  localparam int FIELD_W = 10;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(CHAIN_DEPTH + 1);
  localparam int SADDR_W = $clog2(CHAIN_DEPTH);
  localparam int V_W = ((ROW_W > COORD_BITS) ? ROW_W : COORD_BITS) + 1;
  localparam int PROD_W = 2 * V_W;
  localparam int TURN_W = PROD_W + 1;

  typedef struct packed {
    logic [ROW_W-1:0] y;
    logic [COORD_BITS-1:0] x;
  } pt_t;

  typedef struct packed {
    logic used;
    logic [COORD_BITS-1:0] min;
    logic [COORD_BITS-1:0] max;
  } row_entry_t;

  localparam row_entry_t ROW_CLEAR = '{used: 1'b0, min: {COORD_BITS{1'b1}}, max: '0};

  typedef struct packed {
    logic valid;
    logic pop;
    pt_t pt;
  } chain_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
    logic [CNT_W-1:0] cnt;
    pt_t top;
  } chain_stat_t;
endpackage

// ===== rtl/core/gch_ifaces.sv =====
// Handshake channels for loaded points and hull vertices.
interface gch_point_if import gch_pkg::*;;
  logic valid;
  logic ready;
  logic [FIELD_W-1:0] point_x;
  logic [FIELD_W-1:0] point_y;
  logic last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface gch_hull_if import gch_pkg::*;;
  logic valid;
  logic ready;
  logic [FIELD_W-1:0] hull_x;
  logic [FIELD_W-1:0] hull_y;
  logic chain_side;
  logic chain_overflow;
  logic last_vertex;
  modport source (output valid, hull_x, hull_y, chain_side, chain_overflow, last_vertex,
                  input ready);
  modport sink (input valid, hull_x, hull_y, chain_side, chain_overflow, last_vertex,
                output ready);
endinterface

// ===== rtl/core/gch_row_store.sv =====
// Row table memory with read-modify-write point loading and clearing writes.
module gch_row_store import gch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic ld_en,
  input  logic [ROW_W-1:0] ld_row,
  input  logic [COORD_BITS-1:0] ld_x,
  input  logic sw_en,
  input  logic [ROW_W-1:0] sw_addr,
  output row_entry_t rd
);
  row_entry_t mem [ROWS];
  row_entry_t rdq;
  logic s1_v;
  logic [ROW_W-1:0] s1_row;
  logic [COORD_BITS-1:0] s1_x;
  logic w_v;
  logic [ROW_W-1:0] w_row;
  row_entry_t w_data;
  row_entry_t base;
  row_entry_t merged;
  logic [ROW_W-1:0] raddr;

  assign raddr = ld_en ? ld_row : sw_addr;
  assign rd = rdq;

  always_comb begin
    base = (w_v && w_row == s1_row) ? w_data : rdq;
    merged.used = 1'b1;
    merged.min = (s1_x < base.min) ? s1_x : base.min;
    merged.max = (s1_x > base.max) ? s1_x : base.max;
  end

  always_ff @(posedge clk) begin
    rdq <= mem[raddr];
    if (s1_v) begin
      mem[s1_row] <= merged;
    end else if (sw_en) begin
      mem[sw_addr] <= ROW_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      w_v <= 1'b0;
    end else begin
      s1_v <= ld_en;
      w_v <= s1_v;
    end
    s1_row <= ld_row;
    s1_x <= ld_x;
    w_row <= s1_row;
    w_data <= merged;
  end
endmodule

// ===== rtl/core/gch_chain.sv =====
// One hull chain: stack memory with cached top entries and a turn test unit.
`include "grid_convex_hull_macros.svh"
module gch_chain import gch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic right,
  input  logic clr,
  input  chain_cmd_t cmd,
  input  logic rd_en,
  input  logic [SADDR_W-1:0] rd_addr,
  output pt_t rd_data,
  output chain_stat_t stat
);
  typedef enum logic [2:0] {C_IDLE, C_MUL, C_CMP, C_REFILL, C_PUSH} cstate_t;

  cstate_t st;
  pt_t mem [CHAIN_DEPTH];
  pt_t rdq;
  pt_t top1;
  pt_t top2;
  pt_t pt;
  logic [CNT_W-1:0] cnt;
  logic ovf;
  logic done;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [V_W-1:0] ex;
  logic signed [V_W-1:0] ey;
  logic signed [V_W-1:0] fx;
  logic signed [V_W-1:0] fy;
  logic signed [TURN_W-1:0] turn;
  logic wrong;
  logic [CNT_W-1:0] cnt_m3;
  logic [SADDR_W-1:0] raddr;

  always_comb begin
    ex = V_W'(top1.x) - V_W'(top2.x);
    ey = V_W'(pt.y) - V_W'(top2.y);
    fy = V_W'(top1.y) - V_W'(top2.y);
    fx = V_W'(pt.x) - V_W'(top2.x);
    turn = TURN_W'(p1) - TURN_W'(p2);
    wrong = right ? turn[TURN_W-1] : (!turn[TURN_W-1] && turn != '0);
    cnt_m3 = cnt - CNT_W'(3);
    raddr = rd_en ? rd_addr : cnt_m3[SADDR_W-1:0];
  end

  assign rd_data = rdq;
  assign stat = '{done: done, ovf: ovf, cnt: cnt, top: top1};

  always_ff @(posedge clk) begin
    rdq <= mem[raddr];
    if (st == C_PUSH && cnt != CNT_W'(CHAIN_DEPTH)) begin
      mem[cnt[SADDR_W-1:0]] <= pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= C_IDLE;
      cnt <= '0;
      ovf <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        C_IDLE: begin
          if (clr) begin
            cnt <= '0;
            ovf <= 1'b0;
          end else if (cmd.valid) begin
            pt <= cmd.pt;
            st <= (cmd.pop && cnt > CNT_W'(1)) ? C_MUL : C_PUSH;
          end
        end
        C_MUL: begin
          p1 <= ex * ey;
          p2 <= fy * fx;
          st <= C_CMP;
        end
        C_CMP: begin
          if (wrong) begin
            cnt <= cnt - CNT_W'(1);
            top1 <= top2;
            st <= (cnt >= CNT_W'(3)) ? C_REFILL : C_PUSH;
          end else begin
            st <= C_PUSH;
          end
        end
        C_REFILL: begin
          top2 <= rdq;
          st <= C_MUL;
        end
        C_PUSH: begin
          if (cnt == CNT_W'(CHAIN_DEPTH)) begin
            ovf <= 1'b1;
          end else begin
            top2 <= top1;
            top1 <= pt;
            cnt <= cnt + CNT_W'(1);
          end
          done <= 1'b1;
          st <= C_IDLE;
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  `GCH_ASSERT_IMPL(a_cnt_range, 1'b1, cnt <= CNT_W'(CHAIN_DEPTH))
  `GCH_ASSERT_IMPL(a_cmd_idle, cmd.valid, st == C_IDLE)
  `GCH_ASSERT_NEXT(a_full_ovf, st == C_PUSH && cnt == CNT_W'(CHAIN_DEPTH), ovf)
endmodule

// ===== rtl/core/grid_convex_hull.sv =====
// Top level of the grid convex hull: row scan sequencer and vertex output.
//
//   channel  direction  payload
//   points   in         point_x, point_y, last_point
//   hull     out        hull_x, hull_y, chain_side, chain_overflow, last_vertex
//
// Points load at one per cycle through a read-modify-write of the row memory.
// After reset the row memory is cleared row by row before points are taken.
// The final point starts a scan that reads each row; a used row pushes its minimum to
// the left chain and its maximum to the right, each chain popping and refilling on wrong turns.
// Each hull vertex is then read out, and a stalled hull channel holds the output.
// The scan clears each row as it reads it, so the next run may start at once.
`include "grid_convex_hull_macros.svh"
module grid_convex_hull import gch_pkg::*; (
  input logic clk,
  input logic rst,
  gch_point_if.sink points,
  gch_hull_if.source hull
);
  typedef enum logic [3:0] {
    S_CLEAR, S_LOAD, S_DRAIN, S_SCAN_RD, S_SCAN_CHK, S_CHAIN, S_WAIT, S_NEXT,
    S_CLOSE, S_OUT_RD, S_OUT_LD
  } state_t;

  state_t st;
  state_t ret;
  logic [ROW_W-1:0] r;
  logic first;
  pt_t lo;
  pt_t hi;
  pt_t top_pt;
  logic l_pend;
  logic r_pend;
  chain_cmd_t l_cmd;
  chain_cmd_t r_cmd;
  chain_stat_t l_stat;
  chain_stat_t r_stat;
  pt_t l_rd;
  pt_t r_rd;
  logic [CNT_W-1:0] k;
  logic side;
  logic out_v;
  pt_t out_pt;
  logic out_side;
  logic out_ovf;
  logic out_last;
  row_entry_t rd;
  logic ld_en;
  logic sw_en;
  logic accept;
  logic [CNT_W-1:0] side_cnt;
  logic [CNT_W-1:0] k_inc;

  assign points.ready = (st == S_LOAD);
  assign accept = points.valid && points.ready;
  assign ld_en = accept && (32'(points.point_y) < 32'(ROWS));
  assign sw_en = (st == S_CLEAR) || (st == S_SCAN_RD);
  assign side_cnt = side ? r_stat.cnt : l_stat.cnt;
  assign k_inc = k + CNT_W'(1);

  assign hull.valid = out_v;
  assign hull.hull_x = FIELD_W'(out_pt.x);
  assign hull.hull_y = FIELD_W'(out_pt.y);
  assign hull.chain_side = out_side;
  assign hull.chain_overflow = out_ovf;
  assign hull.last_vertex = out_last;

  gch_row_store u_rows (
    .clk(clk), .rst(rst),
    .ld_en(ld_en), .ld_row(ROW_W'(points.point_y)), .ld_x(COORD_BITS'(points.point_x)),
    .sw_en(sw_en), .sw_addr(r), .rd(rd)
  );

  gch_chain u_left (
    .clk(clk), .rst(rst), .right(1'b0), .clr(st == S_DRAIN), .cmd(l_cmd),
    .rd_en(st == S_OUT_RD), .rd_addr(k[SADDR_W-1:0]), .rd_data(l_rd), .stat(l_stat)
  );

  gch_chain u_right (
    .clk(clk), .rst(rst), .right(1'b1), .clr(st == S_DRAIN), .cmd(r_cmd),
    .rd_en(st == S_OUT_RD), .rd_addr(k[SADDR_W-1:0]), .rd_data(r_rd), .stat(r_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
      ret <= S_NEXT;
      r <= '0;
      first <= 1'b1;
      l_pend <= 1'b0;
      r_pend <= 1'b0;
      l_cmd <= '0;
      r_cmd <= '0;
      k <= '0;
      side <= 1'b0;
      out_v <= 1'b0;
    end else begin
      l_cmd.valid <= 1'b0;
      r_cmd.valid <= 1'b0;
      if (out_v && hull.ready) begin
        out_v <= 1'b0;
      end
      case (st)
        S_CLEAR: begin
          r <= r + ROW_W'(1);
          if (r == ROW_W'(ROWS - 1)) begin
            r <= '0;
            st <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (accept && points.last_point) begin
            st <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          r <= '0;
          first <= 1'b1;
          st <= S_SCAN_RD;
        end
        S_SCAN_RD: st <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (rd.used) begin
            lo <= '{y: r, x: rd.min};
            hi <= '{y: r, x: rd.max};
            first <= 1'b0;
            if (first && rd.min != rd.max) begin
              r_cmd <= '{valid: 1'b1, pop: 1'b0, pt: '{y: r, x: rd.min}};
              r_pend <= 1'b1;
              ret <= S_CHAIN;
              st <= S_WAIT;
            end else begin
              st <= S_CHAIN;
            end
          end else begin
            st <= S_NEXT;
          end
        end
        S_CHAIN: begin
          l_cmd <= '{valid: 1'b1, pop: 1'b1, pt: lo};
          r_cmd <= '{valid: 1'b1, pop: 1'b1, pt: hi};
          l_pend <= 1'b1;
          r_pend <= 1'b1;
          top_pt <= hi;
          ret <= S_NEXT;
          st <= S_WAIT;
        end
        S_WAIT: begin
          if (l_stat.done) begin
            l_pend <= 1'b0;
          end
          if (r_stat.done) begin
            r_pend <= 1'b0;
          end
          if (!(l_pend && !l_stat.done) && !(r_pend && !r_stat.done)) begin
            st <= ret;
          end
        end
        S_NEXT: begin
          if (r == ROW_W'(ROWS - 1)) begin
            st <= S_CLOSE;
          end else begin
            r <= r + ROW_W'(1);
            st <= S_SCAN_RD;
          end
        end
        S_CLOSE: begin
          k <= '0;
          side <= 1'b0;
          if (first) begin
            st <= S_LOAD;
          end else if (l_stat.top != top_pt) begin
            l_cmd <= '{valid: 1'b1, pop: 1'b0, pt: top_pt};
            l_pend <= 1'b1;
            ret <= S_OUT_RD;
            st <= S_WAIT;
          end else begin
            st <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          if (k == side_cnt) begin
            k <= '0;
            if (side) begin
              st <= S_LOAD;
            end else begin
              side <= 1'b1;
            end
          end else if (!out_v || hull.ready) begin
            st <= S_OUT_LD;
          end
        end
        S_OUT_LD: begin
          out_v <= 1'b1;
          out_pt <= side ? r_rd : l_rd;
          out_side <= side;
          out_ovf <= l_stat.ovf || r_stat.ovf;
          out_last <= side ? (k_inc == r_stat.cnt)
                           : (k_inc == l_stat.cnt && r_stat.cnt == '0);
          k <= k_inc;
          st <= S_OUT_RD;
        end
        default: st <= S_CLEAR;
      endcase
    end
  end

  `GCH_ASSERT_NEXT(a_last_stops, points.valid && points.ready && points.last_point, !points.ready)
  `GCH_ASSERT_IMPL(a_pend_wait, l_pend || r_pend, st == S_WAIT)
  `GCH_ASSERT_IMPL(a_out_free, st == S_OUT_LD, !out_v)
endmodule
